/* hw/rtl/elapsed_time_window_averager_assert.svh */
// Assertion macros for the elapsed-time window averager.
// Expects the including module to have a clock named clk and a reset named arst_n.
`ifndef ELAPSED_TIME_WINDOW_AVERAGER_ASSERT_SVH
`define ELAPSED_TIME_WINDOW_AVERAGER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ETWA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ETWA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/etwa_pkg.sv */
// Shared sizes, types and divider handshake structs for the elapsed-time window averager.
// No dependencies.
`default_nettype none

package etwa_pkg;

	localparam int SAMPLES   = 16;
	localparam int TIME_BITS = 32;

	// Fixed port widths.
	localparam int STAMP_W = 32;
	localparam int AVG_W   = 32;
	localparam int TOTAL_W = 5;

	localparam int SLOT_W    = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam int CNT_W     = $clog2(SAMPLES + 1);
	localparam int SUM_W     = TIME_BITS + $clog2(SAMPLES);
	localparam int DIV_CNT_W = $clog2(SUM_W + 1);

	typedef logic [TIME_BITS-1:0] tick_t;
	typedef logic [SUM_W-1:0]     sum_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [SLOT_W-1:0]    slot_t;

	typedef struct packed {
		logic start;
		sum_t dividend;
		cnt_t divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		sum_t quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/etwa_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module etwa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/etwa_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle, for the running sum over the count.
// Depends on etwa_pkg.
`default_nettype none

module etwa_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire etwa_pkg::div_req_t req,
	output etwa_pkg::div_rsp_t      rsp
);

	logic [etwa_pkg::DIV_CNT_W-1:0] step_q;
	logic                           done_q;
	etwa_pkg::sum_t                 quo_q;
	etwa_pkg::cnt_t                 rem_q;
	etwa_pkg::cnt_t                 dvs_q;

	logic [etwa_pkg::CNT_W:0]   trial;
	logic [etwa_pkg::CNT_W+1:0] diff;
	logic                       borrow;

	assign trial  = {rem_q, quo_q[etwa_pkg::SUM_W-1]};
	assign diff   = {1'b0, trial} - {2'b00, dvs_q};
	assign borrow = diff[etwa_pkg::CNT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (step_q == etwa_pkg::DIV_CNT_W'(1));
			if (req.start) begin
				step_q <= etwa_pkg::DIV_CNT_W'(etwa_pkg::SUM_W);
			end else if (step_q != '0) begin
				step_q <= step_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (step_q != '0) begin
			// Keep the partial remainder when the trial subtraction borrows.
			if (borrow) begin
				rem_q <= trial[etwa_pkg::CNT_W-1:0];
			end else begin
				rem_q <= diff[etwa_pkg::CNT_W-1:0];
			end
			quo_q <= {quo_q[etwa_pkg::SUM_W-2:0], ~borrow};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

/* hw/rtl/elapsed_time_window_averager.sv */
// Elapsed-time window averager: top level. Depends on etwa_pkg, etwa_ram, etwa_div and
// the assertion macros in elapsed_time_window_averager_assert.svh.
`default_nettype none

// The block takes one event beat at a time. A start beat (kind 0) latches its stamp and
// answers at once with the current average and sample count, so its result is in the
// output register on the following cycle. A stop beat (kind 1) turns the stamp into an
// elapsed sample, modulo the time width, stores it in a ring of SAMPLES entries held in
// a synchronous RAM, updates the running sum and the saturating count, and then divides
// the sum by the count. A stop beat runs in steps: the oldest ring entry is read at the
// accepting edge, then the write-back state writes the new sample and updates the sum,
// the go state loads the divider, the restoring divider produces one quotient bit per
// cycle until all SUM_W bits are in, the wait state takes the quotient and the put
// state places the result once the output register is free. The event side opens again
// once the result is placed. The event side stalls while a stop beat is in progress and
// while a finished result is held by a stalled output. Only one beat is in flight, so a
// read of a ring entry never overlaps its write. The ring has no reset; an entry is only
// used once the ring is full, after it was written.
module elapsed_time_window_averager (
	input  wire logic                         clk,
	input  wire logic                         arst_n,

	input  wire logic                         evt_valid,
	output logic                              evt_stall,
	input  wire logic                         kind,
	input  wire logic [etwa_pkg::STAMP_W-1:0] stamp,

	output logic                              res_valid,
	input  wire logic                         res_stall,
	output logic      [etwa_pkg::AVG_W-1:0]   average,
	output logic      [etwa_pkg::TOTAL_W-1:0] sample_total
);

	`include "elapsed_time_window_averager_assert.svh"

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_PUT
	} state_t;

	state_t                         state_q;
	etwa_pkg::tick_t                start_q;
	etwa_pkg::tick_t                elapsed_s1;
	etwa_pkg::slot_t                slot_q;
	etwa_pkg::cnt_t                 count_q;
	etwa_pkg::sum_t                 sum_q;
	logic [etwa_pkg::AVG_W-1:0]     avg_q;
	logic                           res_valid_q;
	logic [etwa_pkg::AVG_W-1:0]     res_avg_q;
	logic [etwa_pkg::TOTAL_W-1:0]   res_total_q;

	etwa_pkg::tick_t    stamp_tick;
	etwa_pkg::tick_t    ram_rdata;
	logic               evt_fire;
	logic               res_free;
	logic               ring_full;
	etwa_pkg::sum_t     oldest;
	etwa_pkg::sum_t     sum_next;
	etwa_pkg::cnt_t     count_next;
	etwa_pkg::slot_t    slot_next;
	etwa_pkg::div_req_t div_req;
	etwa_pkg::div_rsp_t div_rsp;

	// The stamp is taken modulo the time width.
	assign stamp_tick = etwa_pkg::TIME_BITS'(stamp);

	// The output register is free when empty or being emptied in this cycle.
	assign res_free  = !res_valid_q || !res_stall;
	assign evt_stall = (state_q != ST_IDLE) || !res_free;
	assign evt_fire  = evt_valid && !evt_stall;

	assign ring_full  = (count_q == etwa_pkg::CNT_W'(etwa_pkg::SAMPLES));
	assign oldest     = ring_full ? etwa_pkg::SUM_W'(ram_rdata) : '0;
	assign sum_next   = sum_q - oldest + etwa_pkg::SUM_W'(elapsed_s1);
	assign count_next = ring_full ? count_q : count_q + 1'b1;
	assign slot_next  = (slot_q == etwa_pkg::SLOT_W'(etwa_pkg::SAMPLES - 1)) ? '0
	                                                                       : slot_q + 1'b1;

	etwa_ram #(
		.WIDTH (etwa_pkg::TIME_BITS),
		.DEPTH (etwa_pkg::SAMPLES),
		.AW    (etwa_pkg::SLOT_W)
	) u_ring (
		.clk   (clk),
		.we    (state_q == ST_RD),
		.waddr (slot_q),
		.wdata (elapsed_s1),
		.re    (evt_fire && kind),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	// The divider works from the sum and count registered in the write-back cycle.
	assign div_req.start    = (state_q == ST_DIV_GO);
	assign div_req.dividend = sum_q;
	assign div_req.divisor  = count_q;

	etwa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= '0;
			elapsed_s1  <= '0;
			slot_q      <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			avg_q       <= '0;
			res_valid_q <= 1'b0;
			res_avg_q   <= '0;
			res_total_q <= '0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (evt_fire) begin
						if (kind) begin
							elapsed_s1 <= stamp_tick - start_q;
							state_q    <= ST_RD;
						end else begin
							// A start beat leaves the window as it is.
							start_q     <= stamp_tick;
							res_valid_q <= 1'b1;
							res_avg_q   <= avg_q;
							res_total_q <= etwa_pkg::TOTAL_W'(count_q);
						end
					end
				end
				ST_RD: begin
					// The oldest entry is on the RAM output now; it leaves the sum
					// only when the ring is full.
					sum_q   <= sum_next;
					count_q <= count_next;
					slot_q  <= slot_next;
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						avg_q   <= etwa_pkg::AVG_W'(div_rsp.quotient);
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						res_avg_q   <= avg_q;
						res_total_q <= etwa_pkg::TOTAL_W'(count_q);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid    = res_valid_q;
	assign average      = res_avg_q;
	assign sample_total = res_total_q;

	`ETWA_ASSERT_NOW(a_count_bound, 1'b1, count_q <= etwa_pkg::CNT_W'(etwa_pkg::SAMPLES),
		"held sample count above ring size")
	`ETWA_ASSERT_NEXT(a_stop_writes, evt_fire && kind, state_q == ST_RD,
		"stop beat not followed by ring write-back")
	`ETWA_ASSERT_NEXT(a_start_answers, evt_fire && !kind, res_valid_q,
		"start beat did not produce a result")
	`ETWA_ASSERT_NOW(a_div_done_state, div_rsp.done, state_q == ST_DIV_WAIT,
		"divider finished outside the wait state")

endmodule

`default_nettype wire
